>>> hdl/pts_pkg.sv
`timescale 1ns / 1ps
// Package for the periodic task scheduler: sizes, status and operation codes,
// controller states and the structs passed between the controller and the task cells.
package pts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int TIME_W    = 32;
    localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int IDX_W     = 4;
    localparam int STATUS_W  = 2;

    // Operation codes of an input beat
    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_RUN = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_WRAPPED = 2'd2,
        STATUS_EMPTY   = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic              wr;
        logic [SLOT_W-1:0] wr_slot;
        logic              load;
        logic [SLOT_W-1:0] load_slot;
        logic              adv;
        logic [TIME_W-1:0] time_now;
        logic [TIME_W-1:0] period;
    } t_cell_ctl;

    // Report of the cell holding the visit token, zero otherwise
    typedef struct packed {
        logic              fired;
        logic [TIME_W-1:0] elapsed;
    } t_cell_rpt;

endpackage

>>> hdl/pts_cell.sv
`timescale 1ns / 1ps
// One task slot of the scheduler chain: period, last-run time and the visit token.
// Depends on pts_pkg for widths and the control and report structs.
module pts_cell
    import pts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic              i_tok,
    output logic              o_tok,
    output t_cell_rpt         o_rpt
);

    logic              r_tok;
    logic              n_tok;
    logic [TIME_W-1:0] r_period;
    logic [TIME_W-1:0] r_last_run;
    logic [TIME_W-1:0] elapsed;
    logic              fire;

    // Token: load at the newest slot, then pass down one slot per report beat
    always_comb begin
        n_tok = r_tok;
        if (i_ctl.load) begin
            n_tok = (i_ctl.load_slot == i_slot);
        end else if (i_ctl.adv) begin
            n_tok = i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // Due check against the pass time
    assign elapsed = i_ctl.time_now - r_last_run;
    assign fire    = (r_period == '0) || (elapsed > r_period);

    // Store a new task, or stamp the last-run time when the task fires
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && (i_ctl.wr_slot == i_slot)) begin
            r_period   <= i_ctl.period;
            r_last_run <= i_ctl.time_now;
        end else if (i_ctl.adv && r_tok && fire) begin
            r_last_run <= i_ctl.time_now;
        end
    end

    assign o_tok         = r_tok;
    assign o_rpt.fired   = r_tok & fire;
    assign o_rpt.elapsed = r_tok ? elapsed : '0;

endmodule

>>> hdl/periodic_task_scheduler_top.sv
`timescale 1ns / 1ps
// Periodic task scheduler: controller and a chain of MAX_TASKS task cells.
// An add or single-status result is registered and valid in the cycle after the input beat is
// accepted; the first report of a pass over the table follows once the visit token is loaded.
// A run over N tasks first loads the visit token, then gives one report per cycle while the
// output is free as the token steps down the chain; no new input beat is taken until it ends.
// Reset (synchronous, active low) empties the table and clears the previous run time.
module periodic_task_scheduler_top
    import pts_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_func,
    input  logic [TIME_W-1:0]   i_time_now,
    input  logic [TIME_W-1:0]   i_period,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [IDX_W-1:0]    o_task_index,
    output logic                o_fired,
    output logic [TIME_W-1:0]   o_elapsed,
    output logic                o_last
);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_count;
    logic [TIME_W-1:0] r_prev;
    logic [TIME_W-1:0] r_now;
    logic [SLOT_W-1:0] r_slot;
    logic              r_ov;
    t_status           r_status;
    logic [IDX_W-1:0]  r_idx;
    logic              r_fired;
    logic [TIME_W-1:0] r_elapsed;
    logic              r_last;

    logic              out_free;
    logic              acc;
    logic              is_add;
    logic              full;
    logic              wrap;
    logic              empty;
    logic              adv;
    logic              last_slot;
    t_cell_ctl         ctl;
    t_cell_rpt         rpt;
    t_cell_rpt         cell_rpt [MAX_TASKS];
    logic              tok      [MAX_TASKS+1];

    assign out_free  = !r_ov || i_out_ready;
    assign acc       = i_in_valid && o_in_ready;
    assign is_add    = (i_func == FUNC_ADD);
    assign full      = (r_count == CNT_W'(MAX_TASKS));
    assign wrap      = (i_time_now < r_prev);
    assign empty     = (r_count == '0);
    assign last_slot = (r_slot == '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && !is_add && !wrap && !empty) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free && last_slot) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Controller outputs
    always_comb begin
        o_in_ready    = 1'b0;
        adv           = 1'b0;
        ctl.time_now  = i_time_now;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = out_free;
            end
            ST_RUN: begin
                adv          = out_free;
                ctl.time_now = r_now;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        ctl.wr        = acc && is_add && !full;
        ctl.wr_slot   = SLOT_W'(r_count);
        ctl.load      = acc && !is_add && !wrap && !empty;
        ctl.load_slot = SLOT_W'(r_count - CNT_W'(1));
        ctl.adv       = adv;
        ctl.period    = i_period;
    end

    // Cell chain: the token enters at the top and walks toward slot 0
    assign tok[MAX_TASKS] = 1'b0;

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        pts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_slot  (SLOT_W'(g)),
            .i_tok   (tok[g+1]),
            .o_tok   (tok[g]),
            .o_rpt   (cell_rpt[g])
        );
    end

    // Merge reports; only the token holder drives nonzero
    always_comb begin
        rpt = '0;
        for (int k = 0; k < MAX_TASKS; k++) begin
            rpt = rpt | cell_rpt[k];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_prev  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctl.wr) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (acc && !is_add) begin
                r_prev <= i_time_now;
            end
            if (acc) begin
                r_ov <= !ctl.load;
            end else if (adv) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Pass time and slot being reported
    always_ff @(posedge i_clk) begin
        if (ctl.load) begin
            r_now  <= i_time_now;
            r_slot <= ctl.load_slot;
        end else if (adv) begin
            r_slot <= r_slot - SLOT_W'(1);
        end
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_idx     <= '0;
            r_fired   <= 1'b0;
            r_elapsed <= '0;
            r_last    <= 1'b1;
            if (is_add) begin
                if (full) begin
                    r_status <= STATUS_FULL;
                end else begin
                    r_status <= STATUS_OK;
                    r_idx    <= IDX_W'(r_count);
                end
            end else if (wrap) begin
                r_status <= STATUS_WRAPPED;
            end else begin
                r_status <= STATUS_EMPTY;
            end
        end else if (adv) begin
            r_status  <= STATUS_OK;
            r_idx     <= IDX_W'(r_slot);
            r_fired   <= rpt.fired;
            r_elapsed <= rpt.elapsed;
            r_last    <= last_slot;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_status     = r_status;
    assign o_task_index = r_idx;
    assign o_fired      = r_fired;
    assign o_elapsed    = r_elapsed;
    assign o_last       = r_last;

endmodule

>>> tb/tb_periodic_task_scheduler_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for periodic_task_scheduler_top: adds tasks, runs passes and checks
// every result beat against a behavioral table predictor. Depends on pts_pkg and the top level.
module tb_periodic_task_scheduler_top;
    import pts_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic              func;
        logic [TIME_W-1:0] time_now;
        logic [TIME_W-1:0] period;
    } t_sched_item;

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  task_index;
        logic              fired;
        logic [TIME_W-1:0] elapsed;
        logic              last;
    } t_sched_result;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                i_func       = FUNC_ADD;
    logic [TIME_W-1:0]   i_time_now   = '0;
    logic [TIME_W-1:0]   i_period     = '0;
    logic                i_out_ready  = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [IDX_W-1:0]    o_task_index;
    logic                o_fired;
    logic [TIME_W-1:0]   o_elapsed;
    logic                o_last;

    periodic_task_scheduler_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_time_now   (i_time_now),
        .i_period     (i_period),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_task_index (o_task_index),
        .o_fired      (o_fired),
        .o_elapsed    (o_elapsed),
        .o_last       (o_last)
    );

    // Stimulus and expectation stores
    t_sched_item   pending_items[$];
    t_sched_result expected_reports[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_armed  = 1'b0;
    int mismatches    = 0;
    int idle_cycles   = 0;

    // Generator state: its own notion of the timer and of how many adds were issued
    logic [TIME_W-1:0] gen_clock = '0;
    int gen_adds = 0;

    // Predictor copy of the task table
    int                tbl_count = 0;
    logic [TIME_W-1:0] tbl_period   [MAX_TASKS];
    logic [TIME_W-1:0] tbl_last_run [MAX_TASKS];
    logic [TIME_W-1:0] tbl_prev_run = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void queue_report(t_status st, int slot, logic due,
                                         logic [TIME_W-1:0] el, logic fin);
        t_sched_result r;
        r.status     = st;
        r.task_index = slot[IDX_W-1:0];
        r.fired      = due;
        r.elapsed    = el;
        r.last       = fin;
        expected_reports.push_back(r);
    endfunction

    // Advance the table for one accepted beat and queue the reports it causes
    function automatic void schedule_step(logic func, logic [TIME_W-1:0] now,
                                          logic [TIME_W-1:0] per);
        logic [TIME_W-1:0] el;
        logic due;
        if (func == FUNC_ADD) begin
            if (tbl_count >= MAX_TASKS) begin
                queue_report(STATUS_FULL, 0, 1'b0, '0, 1'b1);
            end else begin
                tbl_period[tbl_count]   = per;
                tbl_last_run[tbl_count] = now;
                queue_report(STATUS_OK, tbl_count, 1'b0, '0, 1'b1);
                tbl_count++;
            end
        end else if (now < tbl_prev_run) begin
            tbl_prev_run = now;
            queue_report(STATUS_WRAPPED, 0, 1'b0, '0, 1'b1);
        end else begin
            tbl_prev_run = now;
            if (tbl_count == 0) begin
                queue_report(STATUS_EMPTY, 0, 1'b0, '0, 1'b1);
            end else begin
                // Walk newest to oldest
                for (int s = tbl_count - 1; s >= 0; s--) begin
                    el  = now - tbl_last_run[s];
                    due = (tbl_period[s] == '0) || (el > tbl_period[s]);
                    if (due) tbl_last_run[s] = now;
                    queue_report(STATUS_OK, s, due, el, s == 0);
                end
            end
        end
    endfunction

    function automatic void report_mismatch(string what, t_sched_result want,
                                            t_sched_result got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s: expected st=%0d idx=%0d fired=%0b el=%h last=%0b, got st=%0d idx=%0d fired=%0b el=%h last=%0b",
                     $realtime, what, want.status, want.task_index, want.fired, want.elapsed,
                     want.last, got.status, got.task_index, got.fired, got.elapsed, got.last);
        end
    endfunction

    task automatic push_item(logic func, logic [TIME_W-1:0] now, logic [TIME_W-1:0] per);
        t_sched_item it;
        it.func     = func;
        it.time_now = now;
        it.period   = per;
        pending_items.push_back(it);
        if (func == FUNC_ADD) gen_adds++;
    endtask

    // Mostly runs on an advancing timer, some adds, a few jumps to random times
    task automatic gen_random_items(int count);
        int pick;
        logic [TIME_W-1:0] per;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                case ($urandom_range(9))
                    0, 1:    per = '0;
                    2, 3, 4: per = $urandom_range(40, 1);
                    default: per = $urandom;
                endcase
                if ($urandom_range(9) == 0) push_item(FUNC_ADD, $urandom, per);
                else push_item(FUNC_ADD, gen_clock, per);
            end else if (pick < 22) begin
                gen_clock = $urandom;
                push_item(FUNC_RUN, gen_clock, $urandom);
            end else begin
                gen_clock = gen_clock + $urandom_range(40);
                push_item(FUNC_RUN, gen_clock, $urandom);
            end
        end
    endtask

    task automatic wait_items_taken();
        while (pending_items.size() != 0) @(negedge i_clk);
    endtask

    // Main sequence
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Phase one: sender idles rarely, receiver often
        send_idle_pct = 24;
        recv_idle_pct = 76;
        push_item(FUNC_RUN, 32'd0, 32'hFFFF_FFFF);       // empty table at time zero
        push_item(FUNC_RUN, 32'd100, 32'd0);             // empty table
        push_item(FUNC_RUN, 32'd50, 32'd0);              // timer went backwards
        push_item(FUNC_RUN, 32'd50, 32'd0);              // same time is no wrap
        push_item(FUNC_ADD, 32'd60, 32'd0);              // period zero fires every pass
        push_item(FUNC_RUN, 32'd60, 32'd0);
        push_item(FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(FUNC_RUN, 32'd70, 32'd0);              // elapsed across the timer wrap
        push_item(FUNC_ADD, 32'd70, 32'd5);
        push_item(FUNC_RUN, 32'd75, 32'd0);              // elapsed equal to period: no fire
        push_item(FUNC_RUN, 32'd76, 32'd0);              // one past the period: fire
        push_item(FUNC_ADD, 32'd0, 32'd1);
        push_item(FUNC_RUN, 32'hFFFF_FFFF, 32'd0);       // largest time
        push_item(FUNC_RUN, 32'd0, 32'd0);               // wrap to zero
        push_item(FUNC_ADD, 32'd0, 32'h8000_0000);
        push_item(FUNC_RUN, 32'h8000_0000, 32'd0);
        push_item(FUNC_RUN, 32'h8000_0001, 32'd0);
        gen_clock = 32'h8000_0001;
        gen_random_items(40);
        wait_items_taken();

        // Phase two: the other way round, then fill the table past full
        send_idle_pct = 76;
        recv_idle_pct = 24;
        gen_random_items(50);
        while (gen_adds < MAX_TASKS + 3) begin
            push_item(FUNC_ADD, gen_clock, $urandom_range(30));
        end
        wait_items_taken();

        // Phase three: no idling, with one long receiver hold-off to back up the block
        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_random_items(55);
        hold_armed = 1'b1;
        wait_items_taken();

        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Drive input beats from the pending queue; hold the beat until it is taken
    always @(posedge i_clk) begin
        t_sched_item nxt;
        logic stalled;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            stalled = i_in_valid && !o_in_ready;
            if (i_in_valid && o_in_ready) void'(pending_items.pop_front());
            if (!stalled) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_items[0];
                    i_in_valid <= 1'b1;
                    i_func     <= nxt.func;
                    i_time_now <= nxt.time_now;
                    i_period   <= nxt.period;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Drive output ready: random stalls, plus one long hold-off when armed
    always @(posedge i_clk) begin
        static int hold_left = 0;
        static logic hold_done = 1'b0;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check result beats first, then predict from any input beat taken on this edge
    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.status     = t_status'(o_status);
                got.task_index = o_task_index;
                got.fired      = o_fired;
                got.elapsed    = o_elapsed;
                got.last       = o_last;
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected result", '0, got);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.status !== want.status || got.task_index !== want.task_index ||
                        got.fired !== want.fired || got.elapsed !== want.elapsed ||
                        got.last !== want.last) begin
                        report_mismatch("result mismatch", want, got);
                    end
                end
            end
            if (i_in_valid && o_in_ready) schedule_step(i_func, i_time_now, i_period);
        end
    end

    // Watchdog: stop when work is outstanding but no beat moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n && (pending_items.size() != 0 || expected_reports.size() != 0) &&
            !(i_in_valid && o_in_ready) && !(o_out_valid && i_out_ready)) begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

endmodule

>>> files.f
hdl/pts_pkg.sv
hdl/pts_cell.sv
hdl/periodic_task_scheduler_top.sv
tb/tb_periodic_task_scheduler_top.sv
